/* rtl/srol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srol_pkg
// Shared codes and types for the sorted range owner lookup.
// ----------------------------------------------------------------------------
package srol_pkg;

  localparam int CODE_W = 12;

  // request kinds
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_FETCH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

/* rtl/srol_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sorted_range_owner_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_owner_lookup
// Table of (start, code) pairs with floor lookup by binary search.
// ----------------------------------------------------------------------------
// Each request clears the table, appends a pair at its end, or looks up a
// position; every request gives one result. Pairs sit in one RAM with a
// registered read, so the bisection issues one read per cycle: the compare
// of the returned start picks the next midpoint in the same cycle. A lookup
// searches a non-empty table, fetches the code of the floor entry if there
// is one, and posts the result; clear and append post theirs with no search.
// One request is in flight at a time, but the next is taken while a result
// still waits in the output register. The RAM needs no clearing pass: only
// entries below the fill count are read.
module sorted_range_owner_lookup
  import srol_pkg::*;
#(
  parameter int TABLE_DEPTH   = 512,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [POSITION_BITS-1:0] position,
  input  logic [CODE_W-1:0]        var_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CODE_W-1:0]        found_code,
  output logic [1:0]               status
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = POSITION_BITS + CODE_W;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            lo, lo_next;
  logic [CW-1:0]            hi, hi_next;
  logic [POSITION_BITS-1:0] hi_start, hi_start_next;
  logic [IW-1:0]            mid, mid_next;
  logic [POSITION_BITS-1:0] pos_q, pos_q_next;
  logic [CODE_W-1:0]        res_code, res_code_next;
  logic [1:0]               res_status, res_status_next;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic [IW-1:0]            ram_raddr;
  logic [DW-1:0]            ram_rdata;
  logic [POSITION_BITS-1:0] rd_start;
  logic [CODE_W-1:0]        rd_code;

  // search step
  logic                     start_lt;
  logic [CW-1:0]            lo_n, hi_n;
  logic [POSITION_BITS-1:0] hs_n;
  logic [CW:0]              mid_sum;
  logic [CW-1:0]            cnt_half;
  logic [CW-1:0]            hi_m1;
  logic                     take_prev;

  srol_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({position, var_code}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_start  = ram_rdata[CODE_W +: POSITION_BITS];
  assign rd_code   = ram_rdata[CODE_W-1:0];
  assign ram_waddr = count[IW-1:0];
  assign in_ready  = (state == S_IDLE);

  assign start_lt  = (rd_start < pos_q);
  assign lo_n      = start_lt ? (CW'(mid) + CW'(1)) : lo;
  assign hi_n      = start_lt ? hi : CW'(mid);
  assign hs_n      = start_lt ? hi_start : rd_start;
  assign mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
  assign cnt_half  = count >> 1;
  assign hi_m1     = hi_n - CW'(1);
  // floor is the entry before hi unless start[hi] equals the position
  assign take_prev = (hi_n == count) || (pos_q < hs_n);

  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    hi_start_next   = hi_start;
    mid_next        = mid;
    pos_q_next      = pos_q;
    res_code_next   = res_code;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_raddr       = mid;

    unique case (state)
      S_IDLE: begin
        ram_raddr = cnt_half[IW-1:0];
        if (in_valid) begin
          pos_q_next      = position;
          res_code_next   = '0;
          res_status_next = ST_OK;
          state_next      = S_DONE;
          unique case (mode)
            MODE_CLEAR: begin
              count_next = '0;
            end
            MODE_APPEND: begin
              if (count < CW'(TABLE_DEPTH)) begin
                ram_we     = 1'b1;
                count_next = count + CW'(1);
              end else begin
                res_status_next = ST_FULL;
              end
            end
            MODE_LOOKUP: begin
              if (count == '0) begin
                res_status_next = ST_NONE;
              end else begin
                lo_next    = '0;
                hi_next    = count;
                mid_next   = cnt_half[IW-1:0];
                state_next = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        lo_next       = lo_n;
        hi_next       = hi_n;
        hi_start_next = hs_n;
        if (lo_n < hi_n) begin
          mid_next  = mid_sum[IW:1];
          ram_raddr = mid_sum[IW:1];
        end else if (take_prev && (hi_n == '0)) begin
          res_status_next = ST_NONE;
          state_next      = S_DONE;
        end else begin
          ram_raddr  = take_prev ? hi_m1[IW-1:0] : hi_n[IW-1:0];
          state_next = S_FETCH;
        end
      end

      S_FETCH: begin
        res_code_next   = rd_code;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    hi_start   <= hi_start_next;
    mid        <= mid_next;
    pos_q      <= pos_q_next;
    res_code   <= res_code_next;
    res_status <= res_status_next;
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      found_code <= res_code;
      status     <= res_status;
    end
  end

endmodule
